// File: src/lbd_pkg.sv
`default_nettype none
package lbd_pkg;

    // Operation codes
    localparam logic [3:0] OP_ACCESS     = 4'd0;
    localparam logic [3:0] OP_SET_STATUS = 4'd1;
    localparam logic [3:0] OP_SET_INTEG  = 4'd2;
    localparam logic [3:0] OP_QUERY      = 4'd3;
    localparam logic [3:0] OP_LOCK       = 4'd4;
    localparam logic [3:0] OP_RELEASE    = 4'd5;
    localparam logic [3:0] OP_FIND_VIC   = 4'd6;
    localparam logic [3:0] OP_PUSH       = 4'd7;
    localparam logic [3:0] OP_CLEAN      = 4'd8;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MISS       = 3'd1;
    localparam logic [2:0] ERR_LOCK_INV   = 3'd2;
    localparam logic [2:0] ERR_ALL_PINNED = 3'd3;
    localparam logic [2:0] ERR_CACHED     = 3'd4;
    localparam logic [2:0] ERR_NO_VICTIM  = 3'd5;
    localparam logic [2:0] ERR_NO_FREE    = 3'd6;

    // Block status codes
    localparam logic [1:0] STAT_INVALID  = 2'd0;
    localparam logic [1:0] STAT_MODIFIED = 2'd1;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] addr;
        logic [1:0]  new_status;
        logic        touch;
        logic        use_victim;
        logic [31:0] victim_addr;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  error_code;
        logic [3:0]  slot;
        logic [1:0]  status_out;
        logic        integrity;
        logic        writeback;
        logic [31:0] found_addr;
        logic [4:0]  pinned_count;
    } rsp_t;

endpackage
`default_nettype wire

// File: src/lbd_ram.sv
`default_nettype none
module lbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/lru_block_directory_with_pinning_unit.sv
`default_nettype none
// Fully associative block directory with LRU replacement and slot pinning.
// All per-slot state (tag, status, pin, integrity, recency rank, reuse rank)
// sits in one single-port-read, single-port-write RAM of SLOTS entries, and
// each operation takes two sweeps over it: a read sweep that finds the
// matches, victim, free slot and clean candidate, and a read-modify-write
// sweep that updates ranks and the chosen slot. An operation runs the read
// sweep, a decide step, the update sweep and a load of the output register,
// and the block takes no new request until the operation is through. After
// reset, a clearing pass writes the reset contents before the first request
// is taken. Requests use req_valid and req_ready, results rsp_valid and
// rsp_ready; a result waiting in the output register does not block the next
// request, but that request's operation holds in its final state until the
// waiting result is taken.
module lru_block_directory_with_pinning_unit #(
    parameter int SLOTS     = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lbd_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output lbd_pkg::rsp_t      rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int RW = IW;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = CW;
    localparam int TW = ADDR_BITS;
    localparam int EW = TW + 4 + 2 * RW;
    localparam int P_INV = 0;
    localparam int P_LRU = RW;
    localparam int P_INT = 2 * RW;
    localparam int P_PIN = 2 * RW + 1;
    localparam int P_ST  = 2 * RW + 2;
    localparam int P_TAG = 2 * RW + 4;
    localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);
    localparam logic [RW-1:0] RANK_TOP = RW'(SLOTS - 1);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rv_reg;
    logic [IW-1:0] ridx_reg;
    lbd_pkg::req_t req_reg;

    // Scan accumulators
    logic          a_found_reg, a_found_next;
    logic [IW-1:0] a_idx_reg, a_idx_next;
    logic [EW-1:0] a_ent_reg, a_ent_next;
    logic          v_found_reg, v_found_next;
    logic [IW-1:0] v_idx_reg, v_idx_next;
    logic [EW-1:0] v_ent_reg, v_ent_next;
    logic          any_inv_reg, any_inv_next;
    logic          vic_found_reg, vic_found_next;
    logic [IW-1:0] vic_idx_reg, vic_idx_next;
    logic [EW-1:0] vic_ent_reg, vic_ent_next;
    logic          fr_found_reg, fr_found_next;
    logic [IW-1:0] fr_idx_reg, fr_idx_next;
    logic [EW-1:0] fr_ent_reg, fr_ent_next;
    logic          cl_found_reg, cl_found_next;
    logic [IW-1:0] cl_idx_reg, cl_idx_next;
    logic [EW-1:0] cl_ent_reg, cl_ent_next;

    // Decision
    logic          s_ok_reg, s_ok_next;
    logic [IW-1:0] s_idx_reg, s_idx_next;
    logic [EW-1:0] s_ent_reg, s_ent_next;
    logic          tch_reg, tch_next;
    logic          rm_reg, rm_next;
    logic          psh_reg, psh_next;
    logic [PW-1:0] pt_reg, pt_next;
    lbd_pkg::rsp_t res_reg, res_next;
    lbd_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg, rsp_valid_next;

    // RAM port signals
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, q;

    logic [TW-1:0] q_tag, tag_a, tag_v;
    logic [1:0]    q_st;
    logic          q_pin;
    logic [RW-1:0] q_lru, q_inv;
    logic          is_s;
    logic [RW-1:0] upd_lru, upd_inv;

    lbd_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (q)
    );

    assign q_tag = q[P_TAG +: TW];
    assign q_st  = q[P_ST +: 2];
    assign q_pin = q[P_PIN];
    assign q_lru = q[P_LRU +: RW];
    assign q_inv = q[P_INV +: RW];
    assign tag_a = TW'(req_reg.addr);
    assign tag_v = TW'(req_reg.victim_addr);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer and sweep counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ram_re     = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN, S_UPD:
            begin
                if (cnt_reg != CNT_END)
                begin
                    ram_re   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (!rv_reg)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SCAN) ? S_DECIDE : S_FINISH;
                end
            end
            S_DECIDE:
            begin
                state_next = S_UPD;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Accumulate lookups, victim, free slot and clean candidate
    always_comb
    begin
        a_found_next   = a_found_reg;
        a_idx_next     = a_idx_reg;
        a_ent_next     = a_ent_reg;
        v_found_next   = v_found_reg;
        v_idx_next     = v_idx_reg;
        v_ent_next     = v_ent_reg;
        any_inv_next   = any_inv_reg;
        vic_found_next = vic_found_reg;
        vic_idx_next   = vic_idx_reg;
        vic_ent_next   = vic_ent_reg;
        fr_found_next  = fr_found_reg;
        fr_idx_next    = fr_idx_reg;
        fr_ent_next    = fr_ent_reg;
        cl_found_next  = cl_found_reg;
        cl_idx_next    = cl_idx_reg;
        cl_ent_next    = cl_ent_reg;
        if (state_reg == S_IDLE)
        begin
            a_found_next   = 1'b0;
            v_found_next   = 1'b0;
            any_inv_next   = 1'b0;
            vic_found_next = 1'b0;
            fr_found_next  = 1'b0;
            cl_found_next  = 1'b0;
        end
        else if (state_reg == S_SCAN && rv_reg)
        begin
            if (!a_found_reg && q_tag == tag_a)
            begin
                a_found_next = 1'b1;
                a_idx_next   = ridx_reg;
                a_ent_next   = q;
            end
            if (!v_found_reg && q_tag == tag_v)
            begin
                v_found_next = 1'b1;
                v_idx_next   = ridx_reg;
                v_ent_next   = q;
            end
            if (q_st == lbd_pkg::STAT_INVALID)
            begin
                any_inv_next = 1'b1;
            end
            if (!q_pin && (!vic_found_reg || q_lru < vic_ent_reg[P_LRU +: RW]))
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = ridx_reg;
                vic_ent_next   = q;
            end
            if (q_st == lbd_pkg::STAT_INVALID &&
                (!fr_found_reg || q_inv < fr_ent_reg[P_INV +: RW]))
            begin
                fr_found_next = 1'b1;
                fr_idx_next   = ridx_reg;
                fr_ent_next   = q;
            end
            if (q_st == lbd_pkg::STAT_MODIFIED &&
                (!cl_found_reg || q_tag > cl_ent_reg[P_TAG +: TW]))
            begin
                cl_found_next = 1'b1;
                cl_idx_next   = ridx_reg;
                cl_ent_next   = q;
            end
        end
    end

    // Decide target slot, rank moves and result
    always_comb
    begin
        logic          inst;
        logic          hit;
        logic          wb;
        logic [2:0]    err;
        logic [31:0]   faddr;
        inst       = 1'b0;
        hit        = 1'b0;
        wb         = 1'b0;
        err        = lbd_pkg::ERR_NONE;
        faddr      = '0;
        s_ok_next  = 1'b0;
        s_idx_next = a_idx_reg;
        s_ent_next = a_ent_reg;
        tch_next   = 1'b0;
        rm_next    = 1'b0;
        psh_next   = 1'b0;
        pt_next    = pt_reg;
        case (req_reg.op)
            lbd_pkg::OP_ACCESS, lbd_pkg::OP_QUERY:
            begin
                if (!a_found_reg)
                begin
                    err = lbd_pkg::ERR_MISS;
                end
                else
                begin
                    s_ok_next = 1'b1;
                    if (a_ent_reg[P_ST +: 2] != lbd_pkg::STAT_INVALID)
                    begin
                        hit      = 1'b1;
                        tch_next = (req_reg.op == lbd_pkg::OP_ACCESS) && req_reg.touch;
                    end
                    else
                    begin
                        err = lbd_pkg::ERR_MISS;
                    end
                end
            end
            lbd_pkg::OP_SET_STATUS:
            begin
                if (!a_found_reg)
                begin
                    err = lbd_pkg::ERR_MISS;
                end
                else
                begin
                    s_ok_next = 1'b1;
                    hit       = 1'b1;
                    if (a_ent_reg[P_ST +: 2] == lbd_pkg::STAT_INVALID &&
                        req_reg.new_status != lbd_pkg::STAT_INVALID)
                    begin
                        rm_next = 1'b1;
                    end
                    else if (a_ent_reg[P_ST +: 2] != lbd_pkg::STAT_INVALID &&
                             req_reg.new_status == lbd_pkg::STAT_INVALID)
                    begin
                        psh_next = 1'b1;
                    end
                    s_ent_next[P_ST +: 2] = req_reg.new_status;
                end
            end
            lbd_pkg::OP_SET_INTEG:
            begin
                if (!a_found_reg)
                begin
                    err = lbd_pkg::ERR_MISS;
                end
                else
                begin
                    s_ok_next         = 1'b1;
                    hit               = 1'b1;
                    s_ent_next[P_INT] = 1'b1;
                end
            end
            lbd_pkg::OP_LOCK:
            begin
                if (!a_found_reg)
                begin
                    err = lbd_pkg::ERR_MISS;
                end
                else
                begin
                    s_ok_next = 1'b1;
                    if (a_ent_reg[P_ST +: 2] == lbd_pkg::STAT_INVALID)
                    begin
                        err = lbd_pkg::ERR_LOCK_INV;
                    end
                    else
                    begin
                        hit = 1'b1;
                        if (!a_ent_reg[P_PIN])
                        begin
                            s_ent_next[P_PIN] = 1'b1;
                            pt_next           = pt_reg + PW'(1);
                        end
                    end
                end
            end
            lbd_pkg::OP_RELEASE:
            begin
                if (!a_found_reg)
                begin
                    err = lbd_pkg::ERR_MISS;
                end
                else
                begin
                    s_ok_next = 1'b1;
                    hit       = 1'b1;
                    if (a_ent_reg[P_PIN])
                    begin
                        s_ent_next[P_PIN] = 1'b0;
                        if (pt_reg != '0)
                        begin
                            pt_next = pt_reg - PW'(1);
                        end
                    end
                end
            end
            lbd_pkg::OP_FIND_VIC:
            begin
                if (!any_inv_reg)
                begin
                    if (vic_found_reg)
                    begin
                        s_ok_next  = 1'b1;
                        s_idx_next = vic_idx_reg;
                        s_ent_next = vic_ent_reg;
                        hit        = 1'b1;
                        wb         = (vic_ent_reg[P_ST +: 2] == lbd_pkg::STAT_MODIFIED);
                        faddr      = 32'(vic_ent_reg[P_TAG +: TW]);
                    end
                    else
                    begin
                        err = lbd_pkg::ERR_ALL_PINNED;
                    end
                end
            end
            lbd_pkg::OP_PUSH:
            begin
                if (req_reg.use_victim)
                begin
                    if (a_found_reg)
                    begin
                        err = lbd_pkg::ERR_CACHED;
                    end
                    else if (!v_found_reg)
                    begin
                        err = lbd_pkg::ERR_NO_VICTIM;
                    end
                    else
                    begin
                        s_ok_next  = 1'b1;
                        s_idx_next = v_idx_reg;
                        s_ent_next = v_ent_reg;
                        rm_next    = (v_ent_reg[P_ST +: 2] == lbd_pkg::STAT_INVALID);
                        psh_next   = (req_reg.new_status == lbd_pkg::STAT_INVALID);
                        inst       = 1'b1;
                    end
                end
                else if (!any_inv_reg)
                begin
                    err = lbd_pkg::ERR_NO_FREE;
                end
                else if (a_found_reg && a_ent_reg[P_ST +: 2] != lbd_pkg::STAT_INVALID)
                begin
                    err = lbd_pkg::ERR_CACHED;
                end
                else if (a_found_reg)
                begin
                    s_ok_next = 1'b1;
                    rm_next   = (req_reg.new_status != lbd_pkg::STAT_INVALID);
                    inst      = 1'b1;
                end
                else
                begin
                    s_ok_next  = 1'b1;
                    s_idx_next = fr_idx_reg;
                    s_ent_next = fr_ent_reg;
                    rm_next    = 1'b1;
                    psh_next   = (req_reg.new_status == lbd_pkg::STAT_INVALID);
                    inst       = 1'b1;
                end
            end
            lbd_pkg::OP_CLEAN:
            begin
                if (cl_found_reg)
                begin
                    s_ok_next             = 1'b1;
                    s_idx_next            = cl_idx_reg;
                    s_ent_next            = cl_ent_reg;
                    s_ent_next[P_ST +: 2] = lbd_pkg::STAT_INVALID;
                    psh_next              = 1'b1;
                    hit                   = 1'b1;
                    faddr                 = 32'(cl_ent_reg[P_TAG +: TW]);
                end
            end
            default:
            begin
            end
        endcase

        // Install a new block in the chosen slot
        if (inst)
        begin
            hit = 1'b1;
            if (s_ent_next[P_PIN])
            begin
                s_ent_next[P_PIN] = 1'b0;
                if (pt_reg != '0)
                begin
                    pt_next = pt_reg - PW'(1);
                end
            end
            s_ent_next[P_ST +: 2]  = req_reg.new_status;
            s_ent_next[P_INT]      = 1'b0;
            s_ent_next[P_TAG +: TW] = tag_a;
            tch_next               = 1'b1;
        end

        res_next.hit          = hit;
        res_next.error_code   = err;
        res_next.slot         = s_ok_next ? 4'(s_idx_next) : 4'd0;
        res_next.status_out   = s_ok_next ? s_ent_next[P_ST +: 2] : 2'd0;
        res_next.integrity    = s_ok_next ? s_ent_next[P_INT] : 1'b0;
        res_next.writeback    = wb;
        res_next.found_addr   = faddr;
        res_next.pinned_count = 5'(pt_next);
    end

    // Read-modify-write of each entry during the update sweep
    always_comb
    begin
        is_s    = s_ok_reg && (ridx_reg == s_idx_reg);
        upd_lru = q_lru;
        upd_inv = q_inv;
        if (is_s)
        begin
            upd_lru = tch_reg ? RANK_TOP : q_lru;
            upd_inv = psh_reg ? '0 : q_inv;
        end
        else
        begin
            if (tch_reg && q_lru > s_ent_reg[P_LRU +: RW])
            begin
                upd_lru = q_lru - RW'(1);
            end
            if (q_st == lbd_pkg::STAT_INVALID)
            begin
                upd_inv = q_inv - RW'(rm_reg && (q_inv > s_ent_reg[P_INV +: RW]))
                                + RW'(psh_reg);
            end
        end
    end

    // Drive the RAM write port: clearing pass or update sweep
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ridx_reg;
        ram_wdata = '0;
        if (state_reg == S_INIT)
        begin
            ram_we    = (cnt_reg != CNT_END);
            ram_waddr = cnt_reg[IW-1:0];
            ram_wdata = {TW'(cnt_reg), lbd_pkg::STAT_INVALID, 1'b0, 1'b0,
                         RANK_TOP - cnt_reg[IW-1:0], RANK_TOP - cnt_reg[IW-1:0]};
        end
        else if (state_reg == S_UPD && rv_reg)
        begin
            ram_we = 1'b1;
            if (is_s)
            begin
                ram_wdata = {s_ent_reg[EW-1:P_LRU + RW], upd_lru, upd_inv};
            end
            else
            begin
                ram_wdata = {q[EW-1:P_LRU + RW], upd_lru, upd_inv};
            end
        end
    end

    // Hold the result until the output side takes it
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (state_reg == S_FINISH && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            pt_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            a_found_reg   <= 1'b0;
            v_found_reg   <= 1'b0;
            any_inv_reg   <= 1'b0;
            vic_found_reg <= 1'b0;
            fr_found_reg  <= 1'b0;
            cl_found_reg  <= 1'b0;
            s_ok_reg      <= 1'b0;
            tch_reg       <= 1'b0;
            rm_reg        <= 1'b0;
            psh_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rv_reg        <= ram_re;
            rsp_valid_reg <= rsp_valid_next;
            a_found_reg   <= a_found_next;
            v_found_reg   <= v_found_next;
            any_inv_reg   <= any_inv_next;
            vic_found_reg <= vic_found_next;
            fr_found_reg  <= fr_found_next;
            cl_found_reg  <= cl_found_next;
            if (state_reg == S_DECIDE)
            begin
                pt_reg   <= pt_next;
                s_ok_reg <= s_ok_next;
                tch_reg  <= tch_next;
                rm_reg   <= rm_next;
                psh_reg  <= psh_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ridx_reg    <= cnt_reg[IW-1:0];
        a_idx_reg   <= a_idx_next;
        a_ent_reg   <= a_ent_next;
        v_idx_reg   <= v_idx_next;
        v_ent_reg   <= v_ent_next;
        vic_idx_reg <= vic_idx_next;
        vic_ent_reg <= vic_ent_next;
        fr_idx_reg  <= fr_idx_next;
        fr_ent_reg  <= fr_ent_next;
        cl_idx_reg  <= cl_idx_next;
        cl_ent_reg  <= cl_ent_next;
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        if (state_reg == S_DECIDE)
        begin
            s_idx_reg <= s_idx_next;
            s_ent_reg <= s_ent_next;
            res_reg   <= res_next;
        end
        if (state_reg == S_FINISH && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire

// File: tb/lru_block_directory_with_pinning_unit_tb.sv
`timescale 1ns / 100ps

module lru_block_directory_with_pinning_unit_tb;

    localparam int SLOTS = 16;
    localparam int EXP_DEPTH = 16;
    localparam logic [3:0] OP_UNUSED_LO = 4'h9;
    localparam logic [3:0] OP_UNUSED_HI = 4'hF;

    // Directory predictor and store of expected responses
    class directory_scoreboard;
        logic [31:0]   tags [SLOTS];
        logic [1:0]    stat [SLOTS];
        bit            pin [SLOTS];
        bit            integ [SLOTS];
        int            recency [SLOTS];
        int            reuse [SLOTS];
        int            pins;
        lbd_pkg::rsp_t expected_rsps [EXP_DEPTH];
        int            wr_ptr;
        int            rd_ptr;
        int            pending;
        int            errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                tags[i] = 32'(i);
                stat[i] = lbd_pkg::STAT_INVALID;
                pin[i] = 1'b0;
                integ[i] = 1'b0;
                recency[i] = SLOTS - 1 - i;
                reuse[i] = SLOTS - 1 - i;
            end
            pins = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            pending = 0;
            errors = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
            errors++;
        endtask

        function int find_tag(logic [31:0] a);
            for (int i = 0; i < SLOTS; i++)
                if (tags[i] == a)
                    return i;
            return -1;
        endfunction

        function bit any_free();
            for (int i = 0; i < SLOTS; i++)
                if (stat[i] == lbd_pkg::STAT_INVALID)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void reuse_remove(int s);
            for (int j = 0; j < SLOTS; j++)
                if (j != s && stat[j] == lbd_pkg::STAT_INVALID && reuse[j] > reuse[s])
                    reuse[j]--;
        endfunction

        function void reuse_push_front(int s);
            for (int j = 0; j < SLOTS; j++)
                if (j != s && stat[j] == lbd_pkg::STAT_INVALID)
                    reuse[j]++;
            reuse[s] = 0;
        endfunction

        function void make_recent(int s);
            for (int j = 0; j < SLOTS; j++)
                if (recency[j] > recency[s])
                    recency[j]--;
            recency[s] = SLOTS - 1;
        endfunction

        function void fill_slot(int s, logic [31:0] a, logic [1:0] st);
            if (pin[s])
            begin
                pin[s] = 1'b0;
                if (pins > 0)
                    pins--;
            end
            stat[s] = st;
            integ[s] = 1'b0;
            tags[s] = a;
            make_recent(s);
        endfunction

        // Apply one accepted request and queue its expected response
        function void note_request(lbd_pkg::req_t r);
            lbd_pkg::rsp_t e;
            int            s;
            bit            h;
            bit            wb;
            logic [2:0]    err;
            logic [31:0]   fa;
            s = -1;
            h = 1'b0;
            wb = 1'b0;
            err = lbd_pkg::ERR_NONE;
            fa = '0;
            if (r.op <= lbd_pkg::OP_RELEASE)
            begin
                s = find_tag(r.addr);
                if (s < 0)
                    err = lbd_pkg::ERR_MISS;
                else if (r.op == lbd_pkg::OP_ACCESS || r.op == lbd_pkg::OP_QUERY)
                begin
                    if (stat[s] != lbd_pkg::STAT_INVALID)
                    begin
                        h = 1'b1;
                        if (r.op == lbd_pkg::OP_ACCESS && r.touch)
                            make_recent(s);
                    end
                    else
                        err = lbd_pkg::ERR_MISS;
                end
                else if (r.op == lbd_pkg::OP_SET_STATUS)
                begin
                    if (stat[s] == lbd_pkg::STAT_INVALID &&
                        r.new_status != lbd_pkg::STAT_INVALID)
                        reuse_remove(s);
                    else if (stat[s] != lbd_pkg::STAT_INVALID &&
                             r.new_status == lbd_pkg::STAT_INVALID)
                        reuse_push_front(s);
                    stat[s] = r.new_status;
                    h = 1'b1;
                end
                else if (r.op == lbd_pkg::OP_SET_INTEG)
                begin
                    integ[s] = 1'b1;
                    h = 1'b1;
                end
                else if (r.op == lbd_pkg::OP_LOCK)
                begin
                    if (stat[s] == lbd_pkg::STAT_INVALID)
                        err = lbd_pkg::ERR_LOCK_INV;
                    else
                    begin
                        if (!pin[s])
                        begin
                            pin[s] = 1'b1;
                            pins++;
                        end
                        h = 1'b1;
                    end
                end
                else
                begin
                    if (pin[s])
                    begin
                        pin[s] = 1'b0;
                        if (pins > 0)
                            pins--;
                    end
                    h = 1'b1;
                end
            end
            else if (r.op == lbd_pkg::OP_FIND_VIC)
            begin
                if (!any_free())
                begin
                    for (int j = 0; j < SLOTS; j++)
                        if (!pin[j] && (s < 0 || recency[j] < recency[s]))
                            s = j;
                    if (s < 0)
                        err = lbd_pkg::ERR_ALL_PINNED;
                    else
                    begin
                        h = 1'b1;
                        wb = (stat[s] == lbd_pkg::STAT_MODIFIED);
                        fa = tags[s];
                    end
                end
            end
            else if (r.op == lbd_pkg::OP_PUSH)
            begin
                if (r.use_victim)
                begin
                    if (find_tag(r.addr) >= 0)
                        err = lbd_pkg::ERR_CACHED;
                    else
                    begin
                        s = find_tag(r.victim_addr);
                        if (s < 0)
                            err = lbd_pkg::ERR_NO_VICTIM;
                        else
                        begin
                            if (stat[s] == lbd_pkg::STAT_INVALID)
                                reuse_remove(s);
                            if (r.new_status == lbd_pkg::STAT_INVALID)
                                reuse_push_front(s);
                            fill_slot(s, r.addr, r.new_status);
                            h = 1'b1;
                        end
                    end
                end
                else if (!any_free())
                    err = lbd_pkg::ERR_NO_FREE;
                else
                begin
                    s = find_tag(r.addr);
                    if (s >= 0 && stat[s] != lbd_pkg::STAT_INVALID)
                    begin
                        err = lbd_pkg::ERR_CACHED;
                        s = -1;
                    end
                    else
                    begin
                        if (s >= 0)
                        begin
                            if (r.new_status != lbd_pkg::STAT_INVALID)
                                reuse_remove(s);
                        end
                        else
                        begin
                            // take the front of the reuse order
                            for (int j = 0; j < SLOTS; j++)
                                if (stat[j] == lbd_pkg::STAT_INVALID &&
                                    (s < 0 || reuse[j] < reuse[s]))
                                    s = j;
                            reuse_remove(s);
                            if (r.new_status == lbd_pkg::STAT_INVALID)
                                reuse_push_front(s);
                        end
                        fill_slot(s, r.addr, r.new_status);
                        h = 1'b1;
                    end
                end
            end
            else if (r.op == lbd_pkg::OP_CLEAN)
            begin
                for (int j = 0; j < SLOTS; j++)
                    if (stat[j] == lbd_pkg::STAT_MODIFIED && (s < 0 || tags[j] > tags[s]))
                        s = j;
                if (s >= 0)
                begin
                    stat[s] = lbd_pkg::STAT_INVALID;
                    reuse_push_front(s);
                    h = 1'b1;
                    fa = tags[s];
                end
            end
            e = '0;
            e.hit = h;
            e.error_code = err;
            if (s >= 0)
            begin
                e.slot = s[3:0];
                e.status_out = stat[s];
                e.integrity = integ[s];
            end
            e.writeback = wb;
            e.found_addr = fa;
            e.pinned_count = pins[4:0];
            expected_rsps[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % EXP_DEPTH;
            pending++;
        endfunction

        // Compare one accepted response with the oldest expectation
        task check_response(lbd_pkg::rsp_t g);
            lbd_pkg::rsp_t e;
            if (pending == 0)
            begin
                report("unexpected response", g.found_addr, 32'd0);
                return;
            end
            e = expected_rsps[rd_ptr];
            rd_ptr = (rd_ptr + 1) % EXP_DEPTH;
            pending--;
            if (g.hit !== e.hit)
                report("hit", 32'(g.hit), 32'(e.hit));
            if (g.error_code !== e.error_code)
                report("error_code", 32'(g.error_code), 32'(e.error_code));
            if (g.slot !== e.slot)
                report("slot", 32'(g.slot), 32'(e.slot));
            if (g.status_out !== e.status_out)
                report("status_out", 32'(g.status_out), 32'(e.status_out));
            if (g.integrity !== e.integrity)
                report("integrity", 32'(g.integrity), 32'(e.integrity));
            if (g.writeback !== e.writeback)
                report("writeback", 32'(g.writeback), 32'(e.writeback));
            if (g.found_addr !== e.found_addr)
                report("found_addr", g.found_addr, e.found_addr);
            if (g.pinned_count !== e.pinned_count)
                report("pinned_count", 32'(g.pinned_count), 32'(e.pinned_count));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    lbd_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    lbd_pkg::rsp_t rsp;

    directory_scoreboard dir_sb;
    bit          idle_on;
    bit          hold_rsp;
    int          n_sent;
    logic [31:0] addr_pool [24];

    lru_block_directory_with_pinning_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Accept responses, then pick the next ready level
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
                dir_sb.check_response(rsp);
            if (hold_rsp)
                rsp_ready <= 1'b0;
            else
                rsp_ready <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    // Hold off the receiver long enough to back up the request side
    initial
    begin
        hold_rsp = 1'b0;
        wait (n_sent >= 300);
        @(posedge clk);
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic lbd_pkg::req_t make_req(logic [3:0] op, logic [31:0] a, logic [1:0] st,
                                               bit t, bit uv, logic [31:0] va);
        lbd_pkg::req_t r;
        r.op = op;
        r.addr = a;
        r.new_status = st;
        r.touch = t;
        r.use_victim = uv;
        r.victim_addr = va;
        return r;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send(lbd_pkg::req_t r);
        if (idle_on && $urandom_range(99) < 9)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        dir_sb.note_request(r);
        n_sent++;
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(9) == 0)
            return $urandom;
        return addr_pool[$urandom_range(23)];
    endfunction

    function automatic lbd_pkg::req_t random_req();
        int          w;
        logic [3:0]  op;
        logic [1:0]  st;
        logic [31:0] va;
        w = $urandom_range(99);
        if (w < 25)
            op = lbd_pkg::OP_PUSH;
        else if (w < 40)
            op = lbd_pkg::OP_ACCESS;
        else if (w < 48)
            op = lbd_pkg::OP_QUERY;
        else if (w < 58)
            op = lbd_pkg::OP_SET_STATUS;
        else if (w < 63)
            op = lbd_pkg::OP_SET_INTEG;
        else if (w < 73)
            op = lbd_pkg::OP_LOCK;
        else if (w < 81)
            op = lbd_pkg::OP_RELEASE;
        else if (w < 91)
            op = lbd_pkg::OP_FIND_VIC;
        else if (w < 97)
            op = lbd_pkg::OP_CLEAN;
        else
            op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        st = ($urandom_range(4) == 0) ? lbd_pkg::STAT_INVALID : 2'($urandom_range(1, 3));
        va = ($urandom_range(9) < 7) ? dir_sb.tags[$urandom_range(SLOTS - 1)] : pick_addr();
        return make_req(op, pick_addr(), st, 1'($urandom_range(1)),
                        ($urandom_range(9) < 3), va);
    endfunction

    // Fill every slot, pin them all, probe victim search and push, then release some
    task automatic pin_all_sequence();
        for (int i = 0; i < SLOTS; i++)
            if (dir_sb.stat[i] == lbd_pkg::STAT_INVALID)
                send(make_req(lbd_pkg::OP_SET_STATUS, dir_sb.tags[i],
                              2'($urandom_range(1, 3)), 1'b0, 1'b0, 32'd0));
        for (int i = 0; i < SLOTS; i++)
            send(make_req(lbd_pkg::OP_LOCK, dir_sb.tags[i], 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_FIND_VIC, pick_addr(), 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_PUSH, $urandom, lbd_pkg::STAT_MODIFIED, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_PUSH, $urandom, 2'($urandom_range(3)), 1'b0, 1'b1,
                      dir_sb.tags[$urandom_range(SLOTS - 1)]));
        for (int i = 0; i < SLOTS; i++)
            if ($urandom_range(3) != 0)
                send(make_req(lbd_pkg::OP_RELEASE, dir_sb.tags[i], 2'd0, 1'b0, 1'b0, 32'd0));
    endtask

    initial
    begin
        int guard;
        dir_sb = new();
        idle_on = 1'b1;
        n_sent = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        for (int i = 0; i < 24; i++)
            addr_pool[i] = (i < 16) ? 32'(i) : $urandom;
        addr_pool[16] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corner cases
        send(make_req(lbd_pkg::OP_ACCESS, 32'd5, 2'd0, 1'b1, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_PUSH, 32'hFFFF_FFFF, lbd_pkg::STAT_MODIFIED,
                      1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_QUERY, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_ACCESS, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_LOCK, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_LOCK, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_RELEASE, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_RELEASE, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_SET_INTEG, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_LOCK, 32'd3, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_ACCESS, 32'h1234_5678, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_FIND_VIC, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_PUSH, 32'h55, 2'd2, 1'b0, 1'b1, 32'hAAAA_AAAA));
        send(make_req(lbd_pkg::OP_PUSH, 32'hFFFF_FFFF, 2'd2, 1'b0, 1'b1, 32'd3));
        send(make_req(lbd_pkg::OP_PUSH, 32'h7, 2'd2, 1'b0, 1'b1, 32'd3));
        send(make_req(lbd_pkg::OP_PUSH, 32'hFFFF_FFFF, 2'd2, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_PUSH, 32'd2, lbd_pkg::STAT_INVALID, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_SET_STATUS, 32'h7, lbd_pkg::STAT_INVALID,
                      1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_SET_STATUS, 32'h7, lbd_pkg::STAT_MODIFIED,
                      1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_CLEAN, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_CLEAN, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_CLEAN, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(OP_UNUSED_HI, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send(make_req(OP_UNUSED_LO, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
        send(make_req(lbd_pkg::OP_SET_STATUS, 32'h8765_4321, lbd_pkg::STAT_MODIFIED,
                      1'b0, 1'b0, 32'd0));

        // Random traffic with occasional pin-everything sequences
        while (n_sent < 1450)
        begin
            idle_on = !(n_sent >= 600 && n_sent < 900);
            if ($urandom_range(199) == 0)
                pin_all_sequence();
            else
                send(random_req());
        end
        req_valid <= 1'b0;

        // Drain outstanding responses
        guard = 0;
        while (dir_sb.pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (dir_sb.errors == 0 && dir_sb.pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
